[src/ddac_pkg.sv]
// Shared types, constants and helpers for the dual deploy apogee controller.
`timescale 1ns / 1ps

package ddac_pkg;

   // Altitude samples are signed decimeters
   localparam int ALT_WIDTH = 24;
   // Threshold registers are unsigned decimeters
   localparam int THR_WIDTH = 23;
   // Sums carry one bit beyond the wider operand so they never overflow
   localparam int SUM_WIDTH = ((ALT_WIDTH > THR_WIDTH) ? ALT_WIDTH : (THR_WIDTH + 1)) + 1;
   localparam int CSR_INDEX_WIDTH = 2;

   typedef logic signed [ALT_WIDTH-1:0] alt_type;
   typedef logic [THR_WIDTH-1:0]        thr_type;
   typedef logic signed [SUM_WIDTH-1:0] sum_type;
   typedef logic [CSR_INDEX_WIDTH-1:0]  csr_index_type;
   typedef logic [1:0]                  flight_code_type;

   // Configuration register indexes
   localparam csr_index_type CSR_CLIMB_THRESHOLD   = 2'd0;
   localparam csr_index_type CSR_DESCENT_THRESHOLD = 2'd1;
   localparam csr_index_type CSR_MAIN_HEIGHT       = 2'd2;

   // Reset values of the configuration registers
   localparam thr_type CLIMB_THRESHOLD_RESET   = 23'd100;
   localparam thr_type DESCENT_THRESHOLD_RESET = 23'd50;
   localparam thr_type MAIN_HEIGHT_RESET       = 23'd3000;

   // Flight mode codes as shown on the result channel
   localparam flight_code_type FLIGHT_WAITING = 2'd0;
   localparam flight_code_type FLIGHT_RECORD  = 2'd1;
   localparam flight_code_type FLIGHT_DROGUE  = 2'd2;
   localparam flight_code_type FLIGHT_MAIN    = 2'd3;

   // Internal flight sequencer state
   typedef enum logic [3:0] {
      MODE_WAITING = 4'b0001,
      MODE_RECORD  = 4'b0010,
      MODE_DROGUE  = 4'b0100,
      MODE_MAIN    = 4'b1000
   } mode_type;

   typedef struct packed {
      alt_type altitude;
      logic    arm_released;
   } req_data_type;

   typedef struct packed {
      flight_code_type flight_mode;
      logic            drogue_fire;
      logic            main_fire;
      alt_type         min_altitude;
      alt_type         max_altitude;
   } rsp_data_type;

   typedef struct packed {
      logic          write_en;
      csr_index_type index;
      thr_type       wdata;
   } csr_write_type;

   function automatic sum_type alt_ext(alt_type a);
      return sum_type'(a);
   endfunction

   function automatic sum_type thr_ext(thr_type t);
      return sum_type'(t);
   endfunction

   function automatic flight_code_type flight_code(mode_type m);
      flight_code_type code;
      case (m)
         MODE_WAITING: code = FLIGHT_WAITING;
         MODE_RECORD:  code = FLIGHT_RECORD;
         MODE_DROGUE:  code = FLIGHT_DROGUE;
         MODE_MAIN:    code = FLIGHT_MAIN;
         default:      code = FLIGHT_WAITING;
      endcase
      return code;
   endfunction

endpackage

[src/ddac_track.sv]
// Altitude tracking state, threshold registers and deploy decision logic.
`timescale 1ns / 1ps

module ddac_track (
   input  logic                  clock,
   input  logic                  reset,
   input  ddac_pkg::csr_write_type csr,
   input  logic                  item_accept,
   input  ddac_pkg::req_data_type  item,
   output ddac_pkg::rsp_data_type  result
);

   ddac_pkg::thr_type  climb_ff, climb_in;
   ddac_pkg::thr_type  descent_ff, descent_in;
   ddac_pkg::thr_type  main_height_ff, main_height_in;

   ddac_pkg::mode_type mode_ff, mode_in;
   ddac_pkg::alt_type  low_ff, low_in;
   ddac_pkg::alt_type  high_ff, high_in;
   logic               rising_ff, rising_in;
   logic               falling_ff, falling_in;
   logic               drogue_ff, drogue_in;
   logic               main_ff, main_in;

   // Decode configuration writes; unknown indexes are dropped
   always_comb begin
      climb_in       = climb_ff;
      descent_in     = descent_ff;
      main_height_in = main_height_ff;
      if (csr.write_en) begin
         case (csr.index)
            ddac_pkg::CSR_CLIMB_THRESHOLD:   climb_in       = csr.wdata;
            ddac_pkg::CSR_DESCENT_THRESHOLD: descent_in     = csr.wdata;
            ddac_pkg::CSR_MAIN_HEIGHT:       main_height_in = csr.wdata;
            default: ;
         endcase
      end
   end

   // Evaluate one sample in the same order the flight logic defines
   always_comb begin
      ddac_pkg::alt_type alt;
      alt        = item.altitude;
      mode_in    = mode_ff;
      low_in     = low_ff;
      high_in    = high_ff;
      rising_in  = rising_ff;
      falling_in = falling_ff;
      drogue_in  = drogue_ff;
      main_in    = main_ff;

      // Pulling the pin latches the ground reference and starts recording
      if (mode_ff == ddac_pkg::MODE_WAITING && item.arm_released) begin
         low_in  = alt;
         mode_in = ddac_pkg::MODE_RECORD;
      end

      if (mode_in != ddac_pkg::MODE_WAITING) begin
         if (alt < low_in) begin
            low_in = alt;
         end
         // Hold the maximum at zero until a climb is seen
         if (!rising_in && mode_in == ddac_pkg::MODE_RECORD) begin
            high_in = '0;
         end
         if (!rising_in &&
             ddac_pkg::alt_ext(alt) > ddac_pkg::alt_ext(low_in) + ddac_pkg::thr_ext(climb_ff)) begin
            rising_in = 1'b1;
         end
         if (rising_in && alt > high_in) begin
            high_in = alt;
         end
         // Apogee: drop past the threshold below the maximum fires the drogue
         if (rising_in &&
             ddac_pkg::alt_ext(alt) + ddac_pkg::thr_ext(descent_ff) < ddac_pkg::alt_ext(high_in)) begin
            falling_in = 1'b1;
            rising_in  = 1'b0;
            mode_in    = ddac_pkg::MODE_DROGUE;
            drogue_in  = 1'b1;
         end
         // Below main deploy height over ground fires the main
         if (falling_in &&
             ddac_pkg::alt_ext(alt) <
             ddac_pkg::alt_ext(low_in) + ddac_pkg::thr_ext(main_height_ff)) begin
            mode_in = ddac_pkg::MODE_MAIN;
            main_in = 1'b1;
         end
      end
   end

   // Result of the item presented this cycle
   always_comb begin
      result.flight_mode  = ddac_pkg::flight_code(mode_in);
      result.drogue_fire  = drogue_in;
      result.main_fire    = main_in;
      result.min_altitude = low_in;
      result.max_altitude = high_in;
   end

   // Update configuration on writes, state only on accepted items
   always_ff @(posedge clock) begin
      if (reset) begin
         climb_ff       <= ddac_pkg::CLIMB_THRESHOLD_RESET;
         descent_ff     <= ddac_pkg::DESCENT_THRESHOLD_RESET;
         main_height_ff <= ddac_pkg::MAIN_HEIGHT_RESET;
         mode_ff        <= ddac_pkg::MODE_WAITING;
         low_ff         <= '0;
         high_ff        <= '0;
         rising_ff      <= 1'b0;
         falling_ff     <= 1'b0;
         drogue_ff      <= 1'b0;
         main_ff        <= 1'b0;
      end else begin
         climb_ff       <= climb_in;
         descent_ff     <= descent_in;
         main_height_ff <= main_height_in;
         if (item_accept) begin
            mode_ff    <= mode_in;
            low_ff     <= low_in;
            high_ff    <= high_in;
            rising_ff  <= rising_in;
            falling_ff <= falling_in;
            drogue_ff  <= drogue_in;
            main_ff    <= main_in;
         end
      end
   end

endmodule

[src/dual_deploy_apogee_controller.sv]
// Top level of the dual deploy apogee controller with its result buffer.
// A result is registered into the output entry, or into the skid entry while rsp_stall holds the output.
// Throughput: one item per cycle while req_stall is low; the tracking update is a single pass of compares.
// A two-entry result buffer keeps accepting while one result waits on rsp_stall.
// Reset (synchronous): waiting mode, fire lines low, min/max zero, thresholds default.
`timescale 1ns / 1ps

module dual_deploy_apogee_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ddac_pkg::req_data_type  req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output ddac_pkg::rsp_data_type  rsp_data,
   input  logic                    csr_write_en,
   input  ddac_pkg::csr_index_type csr_index,
   input  ddac_pkg::thr_type       csr_wdata
);

   ddac_pkg::csr_write_type csr;
   ddac_pkg::rsp_data_type  result;
   logic                    item_accept;
   logic                    rsp_taken;

   logic                    out_valid_ff, out_valid_in;
   ddac_pkg::rsp_data_type  out_data_ff, out_data_in;
   logic                    skid_valid_ff, skid_valid_in;
   ddac_pkg::rsp_data_type  skid_data_ff, skid_data_in;

   // Bundle the configuration write
   always_comb begin
      csr.write_en = csr_write_en;
      csr.index    = csr_index;
      csr.wdata    = csr_wdata;
   end

   // Stall only when the skid entry is occupied
   assign req_stall   = skid_valid_ff;
   assign item_accept = req_valid && !skid_valid_ff;
   assign rsp_taken   = out_valid_ff && !rsp_stall;

   ddac_track u_track (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr),
      .item_accept (item_accept),
      .item        (req_data),
      .result      (result)
   );

   // Steer new results into the output or skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_taken) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = item_accept;
            out_data_in  = result;
         end
      end else if (item_accept) begin
         if (out_valid_ff) begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end else begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

[src/ddac_checker.sv]
// Port-level checks for the dual deploy apogee controller and their binding.
`timescale 1ns / 1ps

module ddac_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input ddac_pkg::rsp_data_type rsp_data
);

   // A stalled result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Nothing is shown in the cycle after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Before arming nothing fires and the tracked extremes stay zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.flight_mode == ddac_pkg::FLIGHT_WAITING |->
         !rsp_data.drogue_fire && !rsp_data.main_fire &&
         rsp_data.min_altitude == '0 && rsp_data.max_altitude == '0)
      else $error("activity while waiting");

   // Main never fires without the drogue
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.main_fire |-> rsp_data.drogue_fire)
      else $error("main fired before drogue");

   // Main mode implies the main line is driven
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.flight_mode == ddac_pkg::FLIGHT_MAIN |-> rsp_data.main_fire)
      else $error("main mode without main fire");

endmodule

bind dual_deploy_apogee_controller ddac_checker u_ddac_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[sim/tb_dual_deploy_apogee_controller.sv]
// Self-checking testbench for the dual deploy apogee controller.
`timescale 1ns / 1ps

module tb_dual_deploy_apogee_controller;

   localparam int                      ITEM_TARGET  = 1370;
   localparam int                      DRAIN_LIMIT  = 4000;
   localparam int                      REPORT_LIMIT = 10;
   localparam ddac_pkg::csr_index_type CSR_SPARE    = 2'd3;
   localparam ddac_pkg::thr_type       THR_MAX      = '1;
   localparam longint ALT_TOP    = (longint'(1) <<< (ddac_pkg::ALT_WIDTH - 1)) - 1;
   localparam longint ALT_BOTTOM = -(longint'(1) <<< (ddac_pkg::ALT_WIDTH - 1));

   logic                    clock        = 1'b0;
   logic                    reset        = 1'b1;
   logic                    req_valid    = 1'b0;
   logic                    req_stall;
   ddac_pkg::req_data_type  req_data     = '0;
   logic                    rsp_valid;
   logic                    rsp_stall    = 1'b1;
   ddac_pkg::rsp_data_type  rsp_data;
   logic                    csr_write_en = 1'b0;
   ddac_pkg::csr_index_type csr_index    = ddac_pkg::CSR_CLIMB_THRESHOLD;
   ddac_pkg::thr_type       csr_wdata    = '0;

   // Flight state as predicted from the accepted samples
   ddac_pkg::flight_code_type fl_mode    = ddac_pkg::FLIGHT_WAITING;
   ddac_pkg::alt_type         fl_low     = '0;
   ddac_pkg::alt_type         fl_high    = '0;
   logic                      fl_rising  = 1'b0;
   logic                      fl_falling = 1'b0;
   logic                      fl_drogue  = 1'b0;
   logic                      fl_main    = 1'b0;
   ddac_pkg::thr_type         climb_thr   = ddac_pkg::CLIMB_THRESHOLD_RESET;
   ddac_pkg::thr_type         descent_thr = ddac_pkg::DESCENT_THRESHOLD_RESET;
   ddac_pkg::thr_type         main_thr    = ddac_pkg::MAIN_HEIGHT_RESET;

   ddac_pkg::rsp_data_type expected_status[$];
   int                     fail_count   = 0;
   int                     results_seen = 0;
   int                     items_sent   = 0;
   int                     hold_request = 0;
   int                     hold_left    = 0;
   logic                   calm         = 1'b0;

   dual_deploy_apogee_controller uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("dual_deploy_apogee_controller verification failed");
      $finish;
   end

   function automatic longint pick(input longint lo, input longint hi);
      return longint'($urandom_range(32'(hi), 32'(lo)));
   endfunction

   // Advance the flight state by one sample and return the status it shows
   function automatic ddac_pkg::rsp_data_type predict_flight(input ddac_pkg::alt_type alt,
                                                             input logic arm);
      ddac_pkg::sum_type      alt_w;
      ddac_pkg::sum_type      low_w;
      ddac_pkg::sum_type      high_w;
      ddac_pkg::sum_type      climb_w;
      ddac_pkg::sum_type      descent_w;
      ddac_pkg::sum_type      main_w;
      ddac_pkg::rsp_data_type status;
      climb_w   = ddac_pkg::sum_type'(climb_thr);
      descent_w = ddac_pkg::sum_type'(descent_thr);
      main_w    = ddac_pkg::sum_type'(main_thr);
      alt_w     = ddac_pkg::sum_type'(alt);
      // the pin only counts while waiting
      if (fl_mode == ddac_pkg::FLIGHT_WAITING && arm) begin
         fl_low  = alt;
         fl_mode = ddac_pkg::FLIGHT_RECORD;
      end
      if (fl_mode != ddac_pkg::FLIGHT_WAITING) begin
         if (alt < fl_low) fl_low = alt;
         low_w = ddac_pkg::sum_type'(fl_low);
         if (!fl_rising && fl_mode == ddac_pkg::FLIGHT_RECORD) fl_high = '0;
         if (!fl_rising && alt_w > low_w + climb_w) fl_rising = 1'b1;
         if (fl_rising && alt > fl_high) fl_high = alt;
         high_w = ddac_pkg::sum_type'(fl_high);
         // apogee: drogue
         if (fl_rising && alt_w + descent_w < high_w) begin
            fl_falling = 1'b1;
            fl_rising  = 1'b0;
            fl_mode    = ddac_pkg::FLIGHT_DROGUE;
            fl_drogue  = 1'b1;
         end
         // low enough under canopy: main
         if (fl_falling && alt_w < low_w + main_w) begin
            fl_mode = ddac_pkg::FLIGHT_MAIN;
            fl_main = 1'b1;
         end
      end
      status.flight_mode  = fl_mode;
      status.drogue_fire  = fl_drogue;
      status.main_fire    = fl_main;
      status.min_altitude = fl_low;
      status.max_altitude = fl_high;
      return status;
   endfunction

   task automatic log_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
   endtask

   // Predict on each accepted item, then check each accepted result
   always @(posedge clock) begin
      ddac_pkg::rsp_data_type want;
      if (!reset && req_valid && !req_stall)
         expected_status.push_back(predict_flight(req_data.altitude,
                                                  req_data.arm_released));
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_status.size() == 0) begin
            log_failure($sformatf("result %0d arrived with nothing expected", results_seen));
         end else begin
            want = expected_status.pop_front();
            if (rsp_data.flight_mode !== want.flight_mode ||
                rsp_data.drogue_fire !== want.drogue_fire ||
                rsp_data.main_fire !== want.main_fire ||
                rsp_data.min_altitude !== want.min_altitude ||
                rsp_data.max_altitude !== want.max_altitude) begin
               log_failure($sformatf(
                  {"result %0d: expected mode %0d drogue %b main %b min %0d max %0d, ",
                   "got mode %0d drogue %b main %b min %0d max %0d"},
                  results_seen, want.flight_mode, want.drogue_fire, want.main_fire,
                  want.min_altitude, want.max_altitude, rsp_data.flight_mode,
                  rsp_data.drogue_fire, rsp_data.main_fire, rsp_data.min_altitude,
                  rsp_data.max_altitude));
            end
         end
      end
   end

   // Receiver: random stalls, long hold-offs on request, none while calm
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && (pick(0, 99) < 22);
      end
   end

   // Offer one sample, clamped to the altitude range, and wait for acceptance
   task automatic send_altitude(input longint alt, input logic arm);
      ddac_pkg::req_data_type item;
      if (alt > ALT_TOP) alt = ALT_TOP;
      else if (alt < ALT_BOTTOM) alt = ALT_BOTTOM;
      item.altitude     = ddac_pkg::alt_type'(alt);
      item.arm_released = arm;
      // occasional idle gaps between samples
      if (!calm && pick(0, 99) < 14) begin
         req_valid <= 1'b0;
         repeat (pick(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Drop valid and wait until every expected status has come back
   task automatic drain_results();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_status.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(input ddac_pkg::csr_index_type idx,
                                 input ddac_pkg::thr_type value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         ddac_pkg::CSR_CLIMB_THRESHOLD:   climb_thr   = value;
         ddac_pkg::CSR_DESCENT_THRESHOLD: descent_thr = value;
         ddac_pkg::CSR_MAIN_HEIGHT:       main_thr    = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic ddac_pkg::thr_type pick_threshold(input longint typical);
      case (pick(0, 9))
         0:       return '0;
         1:       return THR_MAX;
         2:       return ddac_pkg::thr_type'($urandom);
         default: return ddac_pkg::thr_type'(pick(0, typical));
      endcase
   endfunction

   // Random samples: mostly near the ground minimum, some over the full range
   task automatic send_noise(input int count);
      repeat (count) begin
         if (pick(0, 3) == 0)
            send_altitude(longint'(ddac_pkg::alt_type'($urandom)), logic'(pick(0, 1)));
         else
            send_altitude(longint'(fl_low) + pick(0, 8000) - 2000, logic'(pick(0, 1)));
      end
   endtask

   // One flight: ground roll, climb past the threshold, apogee, descent past main height
   task automatic fly_profile();
      longint ground;
      longint peak;
      longint floor_alt;
      longint alt;
      longint climb_l;
      longint descent_l;
      longint main_l;
      int     steps;
      climb_l   = longint'(climb_thr);
      descent_l = longint'(descent_thr);
      main_l    = longint'(main_thr);
      ground    = longint'(fl_low) + pick(0, 40);
      repeat (pick(1, 3)) send_altitude(ground + pick(0, 30) - 10, logic'(pick(0, 1)));
      peak  = ground + climb_l + 1 + pick(0, 30000);
      steps = int'(pick(3, 8));
      for (int i = 1; i <= steps; i++)
         send_altitude(ground + (peak - ground) * i / steps, logic'(pick(0, 1)));
      floor_alt = ground + main_l - pick(1, 400);
      if (floor_alt > peak - descent_l - 1) floor_alt = peak - descent_l - 1 - pick(0, 500);
      steps = int'(pick(3, 10));
      for (int i = 1; i <= steps; i++) begin
         alt = peak - (peak - floor_alt) * i / steps;
         // occasional renewed climb on the way down
         if (pick(0, 9) == 0) alt = alt + climb_l + pick(0, 2000);
         send_altitude(alt, logic'(pick(0, 1)));
      end
   endtask

   // Samples while waiting leave the state untouched
   task automatic test_waiting_mode();
      send_altitude(ALT_TOP, 1'b0);
      send_altitude(ALT_BOTTOM, 1'b0);
      send_altitude(0, 1'b0);
      send_altitude(-1, 1'b0);
      send_altitude(5000, 1'b0);
   endtask

   // Arm, then walk each threshold edge of a flight at the reset settings
   task automatic test_first_flight();
      send_altitude(1000, 1'b1);
      send_altitude(1040, 1'b0);
      send_altitude(990, 1'b1);
      send_altitude(1090, 1'b0);
      send_altitude(1091, 1'b0);
      send_altitude(5000, 1'b0);
      send_altitude(9000, 1'b0);
      send_altitude(8950, 1'b0);
      send_altitude(8949, 1'b0);
      send_altitude(5000, 1'b0);
      send_altitude(3990, 1'b0);
      send_altitude(3989, 1'b0);
      // renewed climb returns to drogue mode, then main again
      send_altitude(4200, 1'b0);
      send_altitude(3000, 1'b0);
      send_altitude(10000, 1'b0);
      send_altitude(9940, 1'b0);
   endtask

   task automatic test_threshold_extremes();
      drain_results();
      write_register(ddac_pkg::CSR_CLIMB_THRESHOLD, '0);
      write_register(ddac_pkg::CSR_DESCENT_THRESHOLD, '0);
      write_register(ddac_pkg::CSR_MAIN_HEIGHT, '0);
      repeat (3) fly_profile();
      drain_results();
      // the spare index must not disturb any register
      write_register(CSR_SPARE, ddac_pkg::thr_type'($urandom));
      write_register(ddac_pkg::CSR_CLIMB_THRESHOLD, THR_MAX);
      write_register(ddac_pkg::CSR_DESCENT_THRESHOLD, THR_MAX);
      write_register(ddac_pkg::CSR_MAIN_HEIGHT, THR_MAX);
      repeat (2) fly_profile();
      send_noise(6);
      drain_results();
      write_register(ddac_pkg::CSR_CLIMB_THRESHOLD, ddac_pkg::CLIMB_THRESHOLD_RESET);
      write_register(ddac_pkg::CSR_DESCENT_THRESHOLD, ddac_pkg::DESCENT_THRESHOLD_RESET);
      write_register(ddac_pkg::CSR_MAIN_HEIGHT, ddac_pkg::MAIN_HEIGHT_RESET);
   endtask

   // Hold the receiver off so the block fills and stalls, then let it drain
   task automatic test_backpressure();
      hold_request = 60;
      repeat (3) fly_profile();
      drain_results();
   endtask

   task automatic test_random_flights();
      int phase;
      int phase_start;
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         phase++;
         drain_results();
         if (pick(0, 3) != 0)
            write_register(ddac_pkg::CSR_CLIMB_THRESHOLD, pick_threshold(3000));
         if (pick(0, 3) != 0)
            write_register(ddac_pkg::CSR_DESCENT_THRESHOLD, pick_threshold(2000));
         if (pick(0, 3) != 0)
            write_register(ddac_pkg::CSR_MAIN_HEIGHT, pick_threshold(40000));
         if (pick(0, 7) == 0) write_register(CSR_SPARE, ddac_pkg::thr_type'($urandom));
         // one phase runs with no idling on either side
         calm        = (phase == 4);
         phase_start = items_sent;
         while (items_sent - phase_start < 100 && items_sent < ITEM_TARGET) begin
            if (pick(0, 4) == 0) send_noise(int'(pick(1, 4)));
            else fly_profile();
         end
         calm = 1'b0;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_waiting_mode();
      test_first_flight();
      test_threshold_extremes();
      test_backpressure();
      test_random_flights();
      drain_results();
      repeat (10) @(posedge clock);
      if (expected_status.size() != 0)
         log_failure($sformatf("%0d expected results never arrived", expected_status.size()));
      if (fail_count == 0) begin
         $display("dual_deploy_apogee_controller verification clean");
      end else begin
         $display("dual_deploy_apogee_controller verification failed");
      end
      $finish;
   end

endmodule

[filelist.f]
src/ddac_pkg.sv
src/ddac_track.sv
src/dual_deploy_apogee_controller.sv
src/ddac_checker.sv
sim/tb_dual_deploy_apogee_controller.sv
